>>> hw/rtl/bdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdm_pkg
// Shared types and constants for the background difference mask.
// ----------------------------------------------------------------------------
package bdm_pkg;

    // Default frame geometry
    localparam int FRAME_WIDTH_DEF  = 640;
    localparam int FRAME_HEIGHT_DEF = 480;

    // Field widths fixed by the interface
    localparam int IDX_W  = 19;
    localparam int CH_W   = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 1'b1;

    localparam logic [CH_W-1:0] THRESH_RESET = 8'd20;

    // BT.601 integer gray weights, Q14
    localparam int W_COEF = 14;
    localparam int PROD_W = 22;
    localparam logic [W_COEF-1:0] WEIGHT_R = 14'd4899;
    localparam logic [W_COEF-1:0] WEIGHT_G = 14'd9617;
    localparam logic [W_COEF-1:0] WEIGHT_B = 14'd1868;
    localparam logic [PROD_W-1:0] GRAY_ROUND = 22'd8192;
    localparam int GRAY_SHIFT = 14;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } rgb_t;

    // Access strobe toward the background store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } store_req_t;

endpackage

>>> hw/rtl/background_difference_mask.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// background_difference_mask
// Frame-difference background subtraction on an RGB888 pixel stream.
// ----------------------------------------------------------------------------
//
//  channel | signals                                        | handshake
//  --------+------------------------------------------------+-------------
//  in      | pixel_index, red, green, blue                  | in_valid/in_ready
//  out     | out_red, out_green, out_blue, foreground       | out_valid/out_ready
//  cfg     | cfg_index, cfg_data                            | cfg_write (no wait)
//
//  One pixel per clock while out_ready is high and the store is not busy. Four
//  register stages (store read, absolute difference, weight multiply,
//  sum/compare); out_valid follows the input beat through all four in order.
//  After reset the background store is swept to zero one entry per cycle,
//  covering all FRAME_WIDTH*FRAME_HEIGHT entries (307200 at 640x480); in_ready
//  stays low meanwhile. Each stage has its own valid bit and moves when the stage
//  after it is empty or moving, so a stalled output fills bubbles first.
//
module background_difference_mask #(
    parameter int FRAME_WIDTH  = bdm_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = bdm_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_write,
    input  logic [bdm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bdm_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [bdm_pkg::IDX_W-1:0]        pixel_index,
    input  logic [bdm_pkg::CH_W-1:0]         red,
    input  logic [bdm_pkg::CH_W-1:0]         green,
    input  logic [bdm_pkg::CH_W-1:0]         blue,

    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [bdm_pkg::CH_W-1:0]         out_red,
    output logic [bdm_pkg::CH_W-1:0]         out_green,
    output logic [bdm_pkg::CH_W-1:0]         out_blue,
    output logic                             foreground
);

    localparam int FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    localparam int PW = bdm_pkg::PROD_W;
    localparam int CW = bdm_pkg::CH_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic          capture_reg;
    logic [CW-1:0] thresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capture_reg <= 1'b0;
            thresh_reg  <= bdm_pkg::THRESH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bdm_pkg::REG_CAPTURE: capture_reg <= cfg_data[0];
                bdm_pkg::REG_THRESH:  thresh_reg  <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: each stage loads when it is empty or draining.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ready1, ready2, ready3, ready4;
    logic store_busy;
    logic accept;

    assign ready4   = !v4_reg || out_ready;
    assign ready3   = !v3_reg || ready4;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1 && !store_busy;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ready1) v1_reg <= accept;
            if (ready2) v2_reg <= v1_reg;
            if (ready3) v3_reg <= v2_reg;
            if (ready4) v4_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: address decode, store read (and write in capture mode)
    // ------------------------------------------------------------------
    logic [31:0]         idx_wide;
    logic                in_frame;
    logic [ADDR_W-1:0]   store_addr;
    bdm_pkg::rgb_t       live_pix;
    bdm_pkg::rgb_t       bg_rdata;
    bdm_pkg::store_req_t store_req;

    assign idx_wide   = 32'(pixel_index);
    assign in_frame   = idx_wide < 32'(FRAME_PIXELS);
    assign store_addr = idx_wide[ADDR_W-1:0];
    assign live_pix   = '{r: red, g: green, b: blue};

    // out-of-frame beats neither write nor use the store
    assign store_req.rd_en = accept && in_frame;
    assign store_req.wr_en = accept && in_frame && capture_reg;

    bdm_bg_store #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (store_req),
        .addr  (store_addr),
        .wdata (live_pix),
        .rdata (bg_rdata),
        .busy  (store_busy)
    );

    bdm_pkg::rgb_t pix1_reg;
    logic          inf1_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix1_reg <= live_pix;
            inf1_reg <= in_frame;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: per-channel absolute difference.
    // Capture mode compares against the pixel just written (zero diff);
    // outside the frame the background is black.
    // ------------------------------------------------------------------
    bdm_pkg::rgb_t bg_sel;
    bdm_pkg::rgb_t diff_next;
    bdm_pkg::rgb_t diff2_reg;
    bdm_pkg::rgb_t pix2_reg;

    always_comb
    begin
        if (!inf1_reg)
        begin
            bg_sel = '0;
        end
        else if (capture_reg)
        begin
            bg_sel = pix1_reg;
        end
        else
        begin
            bg_sel = bg_rdata;
        end
        diff_next.r = (pix1_reg.r > bg_sel.r) ? pix1_reg.r - bg_sel.r : bg_sel.r - pix1_reg.r;
        diff_next.g = (pix1_reg.g > bg_sel.g) ? pix1_reg.g - bg_sel.g : bg_sel.g - pix1_reg.g;
        diff_next.b = (pix1_reg.b > bg_sel.b) ? pix1_reg.b - bg_sel.b : bg_sel.b - pix1_reg.b;
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg && ready2)
        begin
            diff2_reg <= diff_next;
            pix2_reg  <= pix1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: weight multiplies (8 x 14 bits each)
    // ------------------------------------------------------------------
    logic [PW-1:0] prod_r_reg, prod_g_reg, prod_b_reg;
    bdm_pkg::rgb_t pix3_reg;

    always_ff @(posedge clk)
    begin
        if (v2_reg && ready3)
        begin
            prod_r_reg <= PW'(diff2_reg.r) * PW'(bdm_pkg::WEIGHT_R);
            prod_g_reg <= PW'(diff2_reg.g) * PW'(bdm_pkg::WEIGHT_G);
            prod_b_reg <= PW'(diff2_reg.b) * PW'(bdm_pkg::WEIGHT_B);
            pix3_reg   <= pix2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: sum with rounding, shift, threshold, mask
    // Max sum is 16384*255 + 8192, which fits in 22 bits.
    // ------------------------------------------------------------------
    logic [PW-1:0] gray_sum;
    logic [CW-1:0] gray;
    logic          fg_next;
    bdm_pkg::rgb_t out_pix_reg;
    logic          fg_reg;

    assign gray_sum = prod_r_reg + prod_g_reg + prod_b_reg + bdm_pkg::GRAY_ROUND;
    assign gray     = gray_sum[bdm_pkg::GRAY_SHIFT +: CW];
    assign fg_next  = gray > thresh_reg;

    always_ff @(posedge clk)
    begin
        if (v3_reg && ready4)
        begin
            fg_reg      <= fg_next;
            out_pix_reg <= fg_next ? pix3_reg : '0;
        end
    end

    assign out_valid  = v4_reg;
    assign out_red    = out_pix_reg.r;
    assign out_green  = out_pix_reg.g;
    assign out_blue   = out_pix_reg.b;
    assign foreground = fg_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_bg_black: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !foreground) |->
            (out_red == '0 && out_green == '0 && out_blue == '0))
        else $error("background beat not black");

    a_out_from_s3: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(v4_reg) |-> $past(v3_reg))
        else $error("output valid without stage 3 data");

    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !ready3) |=> (v2_reg && $stable(diff2_reg) && $stable(pix2_reg)))
        else $error("stage 2 lost data under stall");

endmodule

>>> hw/rtl/bdm_bg_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdm_bg_store
// Frame-sized background memory with registered read and a clearing pass
// after reset.
// ----------------------------------------------------------------------------
module bdm_bg_store #(
    parameter int FRAME_WIDTH  = bdm_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = bdm_pkg::FRAME_HEIGHT_DEF,
    localparam int FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT,
    localparam int ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bdm_pkg::store_req_t req,
    input  logic [ADDR_W-1:0]   addr,
    input  bdm_pkg::rgb_t       wdata,
    output bdm_pkg::rgb_t       rdata,
    output logic                busy
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FRAME_PIXELS - 1);

    bdm_pkg::rgb_t     mem [FRAME_PIXELS];
    bdm_pkg::rgb_t     rd_data_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              busy_reg;
    logic              busy_next;

    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    bdm_pkg::rgb_t     mem_wdata;

    // clear sweep: one entry per cycle, zero written
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        busy_next     = busy_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            busy_reg     <= busy_next;
        end
    end

    assign mem_addr  = busy_reg ? clr_addr_reg : addr;
    assign mem_we    = busy_reg | req.wr_en;
    assign mem_wdata = busy_reg ? '0 : wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rdata = rd_data_reg;
    assign busy  = busy_reg;

    a_clear_ends_at_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> ($past(clr_addr_reg) == LAST_ADDR))
        else $error("clear pass ended early");

endmodule
